FILE: rtl/vfd_pkg.sv
// Shared types and constants for the varint frame deframer.
`default_nettype none

package vfd_pkg;

    localparam int unsigned MaxVarintBytes = 5;
    localparam int unsigned SeenW          = 3;
    localparam int unsigned ShiftW         = 6;
    localparam logic [7:0]  PreambleByte   = 8'h00;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LEN     = 2'd1,
        PH_TYPE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [31:0] message_type;
        logic [31:0] message_length;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/vfd_parse.sv
// Per-byte frame parser: preamble hunt, varint decode and payload tagging.
`default_nettype none

module vfd_parse #(
    parameter int unsigned MAX_VARINT_BYTES = vfd_pkg::MaxVarintBytes
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_in_byte,
    output logic                 o_res_valid,
    output vfd_pkg::t_result     o_res
);
    import vfd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [31:0]       r_accum, n_accum;
    logic [SeenW-1:0]  r_seen, n_seen;
    logic [31:0]       r_len, n_len;
    logic [31:0]       r_type, n_type;
    logic [31:0]       r_rem, n_rem;

    logic [ShiftW-1:0] w_shift;
    logic [31:0]       w_merged;
    logic [SeenW-1:0]  w_seen_inc;
    logic              w_done;
    logic              w_overlong;
    logic              w_fin;

    assign w_shift    = {r_seen, 3'b000} - {{(ShiftW-SeenW){1'b0}}, r_seen};
    assign w_merged   = r_accum | ({25'd0, i_in_byte[6:0]} << w_shift);
    assign w_seen_inc = r_seen + 1'b1;
    assign w_done     = !i_in_byte[7];
    assign w_overlong = i_in_byte[7] && (w_seen_inc >= SeenW'(MAX_VARINT_BYTES));
    assign w_fin      = (r_rem <= 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_accum <= '0;
            r_seen  <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_rem   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_seen  <= n_seen;
            r_len   <= n_len;
            r_type  <= n_type;
            r_rem   <= n_rem;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_accum     = r_accum;
        n_seen      = r_seen;
        n_len       = r_len;
        n_type      = r_type;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, data_byte: 8'd0, message_type: 32'd0,
                        message_length: 32'd0, last: 1'b0};
        case (r_phase)
            PH_HUNT: begin
                if (i_in_byte == PreambleByte) begin
                    n_accum = '0;
                    n_seen  = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN, PH_TYPE: begin
                if (w_done) begin
                    n_accum = '0;
                    n_seen  = '0;
                    if (r_phase == PH_LEN) begin
                        n_len   = w_merged;
                        n_phase = PH_TYPE;
                    end else begin
                        n_type = w_merged;
                        if (r_len == 32'd0) begin
                            n_phase     = PH_HUNT;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_EMPTY;
                            o_res.message_type = w_merged;
                            o_res.last  = 1'b1;
                        end else begin
                            n_rem   = r_len;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else if (w_overlong) begin
                    n_accum     = '0;
                    n_seen      = '0;
                    n_phase     = PH_HUNT;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.last  = 1'b1;
                end else begin
                    n_accum = w_merged;
                    n_seen  = w_seen_inc;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid          = 1'b1;
                o_res.data_byte      = i_in_byte;
                o_res.message_type   = r_type;
                o_res.message_length = r_len;
                o_res.last           = w_fin;
                if (w_fin) begin
                    n_rem   = '0;
                    n_phase = PH_HUNT;
                end else begin
                    n_rem = r_rem - 32'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/vfd_obuf.sv
// Output result register that holds its result while i_stall is high.
`default_nettype none

module vfd_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire vfd_pkg::t_result i_res,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output vfd_pkg::t_result      o_res
);
    import vfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: rtl/varint_frame_deframer.sv
// Top level of the varint length-prefixed frame deframer.
//
//   Side     Handshake               Payload
//   input    i_valid / o_stall       i_in_byte
//   output   o_valid / i_stall       o_kind, o_data_byte, o_message_type,
//                                    o_message_length, o_last
//
// One byte is taken per cycle while o_stall is low; a result appears in the output
// register in the cycle after the byte that causes it is accepted.
// The output register sets the rate: o_stall is high only while it holds a
// result and i_stall is high.
// Reset is synchronous and active low and returns the parser to the preamble hunt.
`default_nettype none

module varint_frame_deframer #(
    parameter int unsigned MAX_VARINT_BYTES = vfd_pkg::MaxVarintBytes
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [31:0]      o_message_type,
    output logic [31:0]      o_message_length,
    output logic             o_last
);
    import vfd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign o_stall  = o_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    vfd_parse #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept),
        .i_in_byte  (i_in_byte),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    vfd_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_accept && w_res_valid),
        .i_res  (w_res),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_res  (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_message_type   = w_out.message_type;
    assign o_message_length = w_out.message_length;
    assign o_last           = w_out.last;

endmodule

`default_nettype wire

FILE: rtl/vfd_checker.sv
// Port-level checks for the deframer, bound to its top level.
`default_nettype none

module vfd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_stall,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [1:0]  o_kind,
    input  wire logic [7:0]  o_data_byte,
    input  wire logic [31:0] o_message_type,
    input  wire logic [31:0] o_message_length,
    input  wire logic        o_last
);
    import vfd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_message_type) && $stable(o_message_length) && $stable(o_last))
        else $error("Stalled result changed or was dropped.");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled without a waiting result.");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> o_last && o_data_byte == 8'd0
            && o_message_type == 32'd0 && o_message_length == 32'd0)
        else $error("Error result carries nonzero fields.");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_EMPTY |-> o_last && o_data_byte == 8'd0
            && o_message_length == 32'd0)
        else $error("Empty-message result is malformed.");

    a_single_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PAYLOAD && o_message_length == 32'd1 |-> o_last)
        else $error("One-byte message payload not marked last.");

endmodule

bind varint_frame_deframer vfd_checker u_vfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_data_byte     (o_data_byte),
    .o_message_type  (o_message_type),
    .o_message_length(o_message_length),
    .o_last          (o_last)
);

`default_nettype wire
